/* rtl/cme_pkg.sv */
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types and fixed field widths of the central moments engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cme_pkg;

    // Result field widths (fixed by the result beat format)
    localparam int MEAN_W  = 16;
    localparam int MOM1_W  = 17;
    localparam int MOM2_W  = 32;
    localparam int MOM3_W  = 49;
    localparam int COUNT_W = 11;

    // Arithmetic wraps at this width; wide products are split at SPLIT_W
    localparam int MODEL_W = 64;
    localparam int SPLIT_W = 32;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_DIVM,
        ST_DEV,
        ST_DIV1,
        ST_DIV2,
        ST_DIV3,
        ST_DONE
    } t_state;

endpackage

/* rtl/cme_ram.sv */
// ----------------------------------------------------------------------------
// cme_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cme_div.sv */
// ----------------------------------------------------------------------------
// cme_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cme_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,   // held stable while busy, nonzero
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;

    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_fit;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, i_den};
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out at the top while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/central_moments_engine.sv */
// ----------------------------------------------------------------------------
// central_moments_engine: batch mean and 1st..3rd central moments.
// Load: one sample beat per cycle. After the last beat the input stalls for
// two read passes over the sample RAM at one entry per cycle, then four
// divisions of DIV_W bits (DIV_W = 62 at default sizes) on the shared
// bit-serial divider, one bit per cycle, and longer while the previous
// result beat is still held.
// Reset (sync, active low) empties the batch; the sample RAM is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module central_moments_engine #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                i_last,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cme_pkg::MEAN_W-1:0]   o_mean,
    output logic signed [cme_pkg::MOM1_W-1:0]   o_moment1,
    output logic        [cme_pkg::MOM2_W-1:0]   o_moment2,
    output logic signed [cme_pkg::MOM3_W-1:0]   o_moment3,
    output logic        [cme_pkg::COUNT_W-1:0]  o_sample_count,
    output logic                                o_overflow
);

    import cme_pkg::*;

    // Widths. Deviations need one bit over a sample. Sums keep their exact
    // value until they reach MODEL_W bits, where they wrap.
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int DEV_W  = SAMPLE_BITS + 1;
    localparam int SQ_W   = (2 * DEV_W > MODEL_W) ? MODEL_W : 2 * DEV_W;
    localparam int CUBE_W = (3 * DEV_W > MODEL_W) ? MODEL_W : 3 * DEV_W;
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int S1_W   = DEV_W + CNT_W;
    localparam int S2_W   = (2 * DEV_W + CNT_W > MODEL_W) ? MODEL_W : 2 * DEV_W + CNT_W;
    localparam int S3_W   = (3 * DEV_W + CNT_W > MODEL_W) ? MODEL_W : 3 * DEV_W + CNT_W;
    localparam int DIV_W  = S3_W;             // widest dividend
    localparam int PP_W   = SPLIT_W + 1 + DEV_W;
    localparam int PIPE   = 5;                // RAM read + 4 deviation stages

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt;         // samples in the current batch
    logic                      r_drop;        // a sample was dropped
    logic [CNT_W-1:0]          r_bcnt;        // count of the batch in work
    logic                      r_bovf;
    logic [CNT_W-1:0]          r_idx;         // read issue index
    logic [PIPE-1:0]           r_v;           // pass pipeline valid bits
    logic                      r_div_busy;
    logic                      r_o_valid;

    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SAMPLE_BITS-1:0] r_mean;
    logic signed [DEV_W-1:0]       r_d;
    logic signed [DEV_W-1:0]       r_d_b;
    logic        [SQ_W-1:0]        r_dd;
    logic signed [PP_W-1:0]        r_pp_lo;
    logic        [SPLIT_W-1:0]     r_pp_hi;
    logic signed [CUBE_W-1:0]      r_d3;
    logic signed [S1_W-1:0]        r_s1;
    logic        [S2_W-1:0]        r_s2;
    logic signed [S3_W-1:0]        r_s3;
    logic signed [S1_W-1:0]        r_m1;
    logic        [S2_W-1:0]        r_m2;
    logic signed [S3_W-1:0]        r_m3;

    logic signed [MEAN_W-1:0]  r_o_mean;
    logic signed [MOM1_W-1:0]  r_o_m1;
    logic        [MOM2_W-1:0]  r_o_m2;
    logic signed [MOM3_W-1:0]  r_o_m3;
    logic        [COUNT_W-1:0] r_o_cnt;
    logic                      r_o_ovf;

    logic                      w_in_acc;
    logic                      w_full;
    logic                      w_ram_we;
    logic                      w_rd_en;
    logic [SAMPLE_BITS-1:0]    w_rdata;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [DIV_W-1:0]          w_div_num;
    logic [DIV_W-1:0]          w_quot;
    logic [DIV_W-1:0]          w_quot_s;
    logic                      w_q_neg;
    logic                      w_out_load;

    logic [SUM_W-1:0]          w_mag_sum;
    logic [S1_W-1:0]           w_mag_s1;
    logic [S3_W-1:0]           w_mag_s3;

    logic signed [2*DEV_W-1:0] w_dsq;
    logic        [MODEL_W-1:0] w_dd64;
    logic signed [PP_W-1:0]    w_pp_lo;
    logic signed [PP_W-1:0]    w_pp_hi;
    logic        [MODEL_W-1:0] w_d3_64;

    logic [MODEL_W-1:0]        w_mean64;
    logic [MODEL_W-1:0]        w_m1_64;
    logic [MODEL_W-1:0]        w_m2_64;
    logic [MODEL_W-1:0]        w_m3_64;
    logic [MODEL_W-1:0]        w_cnt64;

    // ------------------------------------------------------------------
    // Sample RAM and shared divider
    // ------------------------------------------------------------------
    assign w_full   = (r_cnt == CNT_W'(MAX_SAMPLES));
    assign w_in_acc = i_valid && !o_stall;
    assign w_ram_we = w_in_acc && !w_full;   // a beat into a full buffer is dropped

    cme_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (i_sample),
        .i_re    (w_rd_en),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    cme_div #(
        .NUM_W (DIV_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_bcnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Signed dividends go to the divider as magnitudes; sign is put back on
    // the quotient, which gives truncation toward zero.
    assign w_mag_sum = r_sum[SUM_W-1] ? -r_sum : r_sum;
    assign w_mag_s1  = r_s1[S1_W-1]   ? -r_s1  : r_s1;
    assign w_mag_s3  = r_s3[S3_W-1]   ? -r_s3  : r_s3;
    assign w_quot_s  = w_q_neg ? -w_quot : w_quot;

    // ------------------------------------------------------------------
    // Deviation datapath (pass 2)
    // d^3 = d^2 * d is built from two 32-bit halves of d^2, mod 2^64.
    // ------------------------------------------------------------------
    assign w_dsq   = r_d * r_d;
    assign w_dd64  = MODEL_W'(r_dd);
    assign w_pp_lo = $signed({1'b0, w_dd64[SPLIT_W-1:0]}) * r_d_b;
    assign w_pp_hi = $signed({1'b0, w_dd64[MODEL_W-1:SPLIT_W]}) * r_d_b;
    assign w_d3_64 = MODEL_W'(r_pp_lo) + {r_pp_hi, {SPLIT_W{1'b0}}};

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && i_last) n_state = ST_SUM;
            end
            ST_SUM: begin
                if (r_idx == r_bcnt && !r_v[0]) n_state = ST_DIVM;
            end
            ST_DIVM: begin
                if (w_div_done) n_state = ST_DEV;
            end
            ST_DEV: begin
                if (r_idx == r_bcnt && r_v == '0) n_state = ST_DIV1;
            end
            ST_DIV1: begin
                if (w_div_done) n_state = ST_DIV2;
            end
            ST_DIV2: begin
                if (w_div_done) n_state = ST_DIV3;
            end
            ST_DIV3: begin
                if (w_div_done) n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait for the result register to free up
                if (!r_o_valid || !i_stall) n_state = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_stall     = 1'b1;
        w_rd_en     = 1'b0;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_q_neg     = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state) inside
            ST_LOAD: begin
                o_stall = 1'b0;
            end
            ST_SUM, ST_DEV: begin
                w_rd_en = (r_idx < r_bcnt);
            end
            ST_DIVM: begin
                w_div_start = !r_div_busy;
                w_div_num   = DIV_W'(w_mag_sum);
                w_q_neg     = r_sum[SUM_W-1];
            end
            ST_DIV1: begin
                w_div_start = !r_div_busy;
                w_div_num   = DIV_W'(w_mag_s1);
                w_q_neg     = r_s1[S1_W-1];
            end
            ST_DIV2: begin
                w_div_start = !r_div_busy;
                w_div_num   = DIV_W'(r_s2);
            end
            ST_DIV3: begin
                w_div_start = !r_div_busy;
                w_div_num   = DIV_W'(w_mag_s3);
                w_q_neg     = r_s3[S3_W-1];
            end
            ST_DONE: begin
                w_out_load = !r_o_valid || !i_stall;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_cnt      <= '0;
            r_drop     <= 1'b0;
            r_idx      <= '0;
            r_v        <= '0;
            r_div_busy <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_in_acc) begin
                if (w_full) r_drop <= 1'b1;
                else        r_cnt  <= r_cnt + CNT_W'(1);
                if (i_last) begin
                    // next batch starts empty
                    r_cnt  <= '0;
                    r_drop <= 1'b0;
                end
            end

            if (w_in_acc && i_last) begin
                r_idx <= '0;
            end else if (r_state == ST_DIVM && w_div_done) begin
                r_idx <= '0;
            end else if (w_rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end

            // only the RAM stage runs in pass 1
            r_v <= {(r_state == ST_DEV) ? r_v[PIPE-2:0] : (PIPE-1)'(0), w_rd_en};

            if (w_div_start)     r_div_busy <= 1'b1;
            else if (w_div_done) r_div_busy <= 1'b0;

            if (w_out_load)    r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_last) begin
            r_bcnt <= w_full ? r_cnt : r_cnt + CNT_W'(1);
            r_bovf <= r_drop | w_full;
            r_sum  <= '0;
            r_s1   <= '0;
            r_s2   <= '0;
            r_s3   <= '0;
        end else begin
            if (r_v[0] && r_state == ST_SUM) r_sum <= r_sum + SUM_W'($signed(w_rdata));
            if (r_v[1]) r_s1 <= r_s1 + S1_W'(r_d);
            if (r_v[2]) r_s2 <= r_s2 + S2_W'(r_dd);
            if (r_v[4]) r_s3 <= r_s3 + S3_W'(r_d3);
        end

        r_d     <= DEV_W'($signed(w_rdata)) - DEV_W'(r_mean);
        r_d_b   <= r_d;
        r_dd    <= w_dsq[SQ_W-1:0];
        r_pp_lo <= w_pp_lo;
        r_pp_hi <= w_pp_hi[SPLIT_W-1:0];
        r_d3    <= w_d3_64[CUBE_W-1:0];

        if (w_div_done) begin
            unique case (r_state)
                ST_DIVM: r_mean <= w_quot_s[SAMPLE_BITS-1:0];
                ST_DIV1: r_m1   <= w_quot_s[S1_W-1:0];
                ST_DIV2: r_m2   <= w_quot[S2_W-1:0];
                ST_DIV3: r_m3   <= w_quot_s[S3_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register: fields are cut or sign extended to the beat format
    // ------------------------------------------------------------------
    assign w_mean64 = MODEL_W'(r_mean);
    assign w_m1_64  = MODEL_W'(r_m1);
    assign w_m2_64  = MODEL_W'(r_m2);
    assign w_m3_64  = MODEL_W'(r_m3);
    assign w_cnt64  = MODEL_W'(r_bcnt);

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_mean <= w_mean64[MEAN_W-1:0];
            r_o_m1   <= w_m1_64[MOM1_W-1:0];
            r_o_m2   <= w_m2_64[MOM2_W-1:0];
            r_o_m3   <= w_m3_64[MOM3_W-1:0];
            r_o_cnt  <= w_cnt64[COUNT_W-1:0];
            r_o_ovf  <= r_bovf;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_mean         = r_o_mean;
    assign o_moment1      = r_o_m1;
    assign o_moment2      = r_o_m2;
    assign o_moment3      = r_o_m3;
    assign o_sample_count = r_o_cnt;
    assign o_overflow     = r_o_ovf;

`ifndef SYNTH
    // dropping only happens into a full buffer
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drop |-> (r_cnt == CNT_W'(MAX_SAMPLES)))
        else $error("drop flag set with buffer not full");

    // a new result only comes out of the final sequencer step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside done step");

    // divider completes only in a division step
    a_div_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIVM || r_state == ST_DIV1 ||
                        r_state == ST_DIV2 || r_state == ST_DIV3))
        else $error("divider done outside division step");

    // passes never read past the batch, and a batch is never empty
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM || r_state == ST_DEV) |-> (r_idx <= r_bcnt && r_bcnt != '0))
        else $error("read pass out of batch bounds");
`endif

endmodule
